/* rtl/gsc_pkg.sv */
// Shared types, codes and constants for the GPIO set/clear register bank.
`timescale 1ns / 1ps

package gsc_pkg;

  localparam int PIN_COUNT = 32;
  localparam logic [31:0] PIN_MASK = 32'((64'd1 << PIN_COUNT) - 64'd1);

  localparam int MASK_COUNT = 8;

  // access modes
  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_SET    = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_SAMPLE = 2'd3;

  // mask slot that gates irq
  localparam logic [3:0] TGT_IRQ_ENABLE = 4'd4;

  // read-only targets above the eight masks
  localparam logic [3:0] TGT_PINS   = 4'd8;
  localparam logic [3:0] TGT_STATUS = 4'd9;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  target;
    logic [31:0] write_data;
    logic [31:0] pin_levels;
  } in_word_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
  } out_word_t;

endpackage

/* rtl/gpio_set_clear_register_bank_top.sv */
// Top level of the GPIO set/clear register bank: input register, bank logic, result register.
`timescale 1ns / 1ps

// Each word is a register read, a set or clear of one of eight pin masks, or a pin sample;
// every accepted word yields exactly one result word. A word is registered on acceptance,
// passes through the bank's masking logic and lands in the output register; one word is taken
// in every cycle while out_stall stays low. The input register holds a word while the output
// register is full and stalled; in_stall rises only then. Reading the change status clears it,
// and irq in each result shows whether change status AND interrupt enable is nonzero after
// that word.
module gpio_set_clear_register_bank_top import gsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic      s1_valid_r;
  in_word_t  s1_word_r;
  logic      out_valid_r;
  out_word_t out_word_r;
  out_word_t bank_result;
  logic      s1_adv;
  logic      in_take;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  gsc_bank u_bank (
    .clk    (clk),
    .rst_n  (rst_n),
    .apply  (s1_adv),
    .word   (s1_word_r),
    .result (bank_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_word;
    end
    if (s1_adv) begin
      out_word_r <= bank_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* rtl/gsc_bank.sv */
// Mask registers, change status and pin history, with the per-word update and read logic.
`timescale 1ns / 1ps

module gsc_bank import gsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      apply,
  input  in_word_t  word,
  output out_word_t result
);

  logic [31:0] masks_r   [MASK_COUNT];
  logic [31:0] masks_nxt [MASK_COUNT];
  logic [31:0] status_r, status_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic [31:0] cur_r, cur_nxt;

  logic        is_mask;
  logic [2:0]  idx;
  logic [31:0] wdata;
  logic [31:0] pins;
  logic [31:0] rdata;

  assign is_mask = (word.target[3] == 1'b0);
  assign idx     = word.target[2:0];
  assign wdata   = word.write_data & PIN_MASK;
  assign pins    = word.pin_levels & PIN_MASK;

  always_comb begin
    for (int i = 0; i < MASK_COUNT; i++) begin
      masks_nxt[i] = masks_r[i];
    end
    status_nxt = status_r;
    prev_nxt   = prev_r;
    cur_nxt    = cur_r;
    rdata      = '0;

    case (word.mode)
      MODE_READ: begin
        if (is_mask) begin
          rdata = masks_r[idx];
        end else if (word.target == TGT_PINS) begin
          rdata = pins;
        end else if (word.target == TGT_STATUS) begin
          rdata      = status_r;
          status_nxt = '0;  // clear on read
        end
      end
      MODE_SET: begin
        if (is_mask) begin
          masks_nxt[idx] = (masks_r[idx] | wdata) & PIN_MASK;
        end
      end
      MODE_CLEAR: begin
        if (is_mask) begin
          masks_nxt[idx] = masks_r[idx] & ~wdata & PIN_MASK;
        end
      end
      MODE_SAMPLE: begin
        prev_nxt   = cur_r;
        cur_nxt    = pins;
        status_nxt = (status_r | (cur_r ^ pins)) & PIN_MASK;
      end
      default: begin
        rdata = '0;
      end
    endcase

    result.read_data = rdata & PIN_MASK;
    // irq reflects state after this word
    result.irq       = |(status_nxt & masks_nxt[TGT_IRQ_ENABLE[2:0]]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MASK_COUNT; i++) begin
        masks_r[i] <= '0;
      end
      status_r <= '0;
      prev_r   <= '0;
      cur_r    <= '0;
    end else if (apply) begin
      for (int i = 0; i < MASK_COUNT; i++) begin
        masks_r[i] <= masks_nxt[i];
      end
      status_r <= status_nxt;
      prev_r   <= prev_nxt;
      cur_r    <= cur_nxt;
    end
  end

endmodule

/* rtl/gsc_checker.sv */
// Port-level assertions for the GPIO set/clear register bank, bound to the top level.
`timescale 1ns / 1ps

module gsc_checker import gsc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  // a stalled input word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_word))
    else $error("stalled input word changed");

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // input backs up only behind a full, stalled output
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a stalled result");

  // a fresh result follows an accepted input word
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result word without an accepted input word");

  // nothing comes out right after reset
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind gpio_set_clear_register_bank_top gsc_checker u_gsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
